@@ src/ldcs_pkg.sv @@
package ldcs_pkg;

  localparam int OP_W            = 2;
  localparam int IDX_W           = 6;
  localparam int BYTE_W          = 8;
  localparam int TICK_W          = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int PHASE_W         = 3;

  localparam int BYTES_PER_CHIP  = 9;
  localparam int WORDS_PER_FRAME = 12;
  localparam int LATCH_PULSES    = 4;

  localparam logic [TICK_W-1:0] PULSE_TICKS_RST = 16'd250;
  localparam logic [TICK_W-1:0] SETUP_TICKS_RST = 16'd1000;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS = 1'd1;

  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SEND  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SETUP = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HIGH  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LOW   = 3'd4;

  typedef logic [PHASE_W-1:0] phase_t;

endpackage

@@ src/ldcs_if.sv @@
interface ldcs_in_if;
  import ldcs_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  channel_index;
  logic [BYTE_W-1:0] channel_value;
  logic              blank;

  modport source (output valid, operation, channel_index, channel_value, blank,
                  input ready);
  modport sink (input valid, operation, channel_index, channel_value, blank,
                output ready);
endinterface

interface ldcs_out_if;
  logic valid;
  logic ready;
  logic data_pin;
  logic clock_pin;
  logic busy_res;
  logic all_done;

  modport source (output valid, data_pin, clock_pin, busy_res, all_done,
                  input ready);
  modport sink (input valid, data_pin, clock_pin, busy_res, all_done,
                output ready);
endinterface

@@ src/led_driver_chain_serializer.sv @@
// channel   role     fields
// in_ch     sink     operation, channel_index, channel_value, blank
// out_ch    source   data_pin, clock_pin, busy_res, all_done
// cfg       write    cfg_we, cfg_index, cfg_data (pulse_ticks, setup_ticks)
//
// every item gives one result item; a new item is taken each cycle while
// the output register is empty or being drained
// the channel store is read every cycle at the slot of the current word;
// a byte is needed only eight bit ticks after a word change, so the
// registered read never stalls, and a write to that slot is forwarded
// rst (synchronous) clears the store via per-entry valid bits, no sweep
// a stalled output holds its item and holds off input until taken
module led_driver_chain_serializer #(
  parameter int NUM_CHIPS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  ldcs_in_if.sink                       in_ch,
  ldcs_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ldcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldcs_pkg::TICK_W-1:0]   cfg_data
);
  import ldcs_pkg::*;

  localparam int STORE_DEPTH = NUM_CHIPS * BYTES_PER_CHIP;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CHIP_W      = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

  logic [TICK_W-1:0] pulse_ticks, setup_ticks;

  phase_t            phase, phase_next;
  logic [CHIP_W-1:0] chip_counter, chip_counter_next;
  logic [3:0]        word_counter, word_counter_next;
  logic [3:0]        bit_counter, bit_counter_next;
  logic [TICK_W-1:0] delay_counter, delay_counter_next;
  logic [1:0]        pulse_counter, pulse_counter_next;
  logic              clock_level, clock_level_next;
  logic              data_level, data_level_next;
  logic              blank_mode, blank_mode_next;
  logic              done;

  logic [BYTE_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] entry_valid;
  logic [BYTE_W-1:0]      rd_data, fwd_data;
  logic                   rd_valid, fwd_hit;
  logic [AW-1:0]          raddr, waddr;
  logic [7:0]             slot_wide;
  logic                   we;
  logic [BYTE_W-1:0]      cur_byte;
  logic                   bit_val;
  logic [TICK_W-1:0]      half_reload;

  logic accept;
  logic out_valid;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks <= PULSE_TICKS_RST;
      setup_ticks <= SETUP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_TICKS: pulse_ticks <= cfg_data;
        REG_SETUP_TICKS: setup_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // store port: one write, one registered read at the current word's slot
  assign slot_wide = 8'(chip_counter) * 8'(BYTES_PER_CHIP) + 8'(BYTES_PER_CHIP)
                     - 8'(word_counter);
  assign raddr = slot_wide[AW-1:0];
  assign waddr = AW'(in_ch.channel_index);
  assign we    = accept && (in_ch.operation == OP_WRITE)
                 && (int'(in_ch.channel_index) < STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= in_ch.channel_value;
    end
    rd_data  <= mem[raddr];
    fwd_data <= in_ch.channel_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
      fwd_hit     <= 1'b0;
    end else begin
      if (we) begin
        entry_valid[waddr] <= 1'b1;
      end
      rd_valid <= entry_valid[raddr];
      fwd_hit  <= we && (waddr == raddr);
    end
  end

  assign cur_byte = fwd_hit ? fwd_data : (rd_valid ? rd_data : '0);

  // words 1..9 carry bytes, upper byte of each word is zero
  always_comb begin
    bit_val = 1'b0;
    if (!blank_mode && word_counter != 4'd0
        && int'(word_counter) <= BYTES_PER_CHIP && !bit_counter[3]) begin
      bit_val = cur_byte[bit_counter[2:0]];
    end
  end

  assign half_reload = (pulse_ticks == '0) ? '0 : pulse_ticks - 1'b1;

  always_comb begin
    phase_next         = phase;
    chip_counter_next  = chip_counter;
    word_counter_next  = word_counter;
    bit_counter_next   = bit_counter;
    delay_counter_next = delay_counter;
    pulse_counter_next = pulse_counter;
    clock_level_next   = clock_level;
    data_level_next    = data_level;
    blank_mode_next    = blank_mode;
    done               = 1'b0;
    if (accept && in_ch.operation == OP_START && phase == PH_IDLE) begin
      blank_mode_next    = in_ch.blank;
      chip_counter_next  = '0;
      word_counter_next  = '0;
      bit_counter_next   = 4'd15;
      pulse_counter_next = '0;
      phase_next         = PH_SEND;
    end else if (accept && in_ch.operation == OP_TICK) begin
      case (phase)
        PH_SEND: begin
          data_level_next  = bit_val;
          clock_level_next = !clock_level;
          if (bit_counter == 4'd0) begin
            bit_counter_next = 4'd15;
            if (int'(word_counter) >= WORDS_PER_FRAME) begin
              word_counter_next  = '0;
              delay_counter_next = setup_ticks;
              phase_next         = PH_SETUP;
            end else begin
              word_counter_next = word_counter + 4'd1;
            end
          end else begin
            bit_counter_next = bit_counter - 4'd1;
          end
        end
        PH_SETUP: begin
          data_level_next = 1'b0;
          if (delay_counter != '0) begin
            delay_counter_next = delay_counter - 1'b1;
          end else begin
            data_level_next    = 1'b1;
            pulse_counter_next = '0;
            delay_counter_next = half_reload;
            phase_next         = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (delay_counter != '0) begin
            delay_counter_next = delay_counter - 1'b1;
          end else begin
            data_level_next    = 1'b0;
            delay_counter_next = half_reload;
            phase_next         = PH_LOW;
          end
        end
        PH_LOW: begin
          if (delay_counter != '0) begin
            delay_counter_next = delay_counter - 1'b1;
          end else if (int'(pulse_counter) < LATCH_PULSES - 1) begin
            pulse_counter_next = pulse_counter + 2'd1;
            data_level_next    = 1'b1;
            delay_counter_next = half_reload;
            phase_next         = PH_HIGH;
          end else begin
            pulse_counter_next = '0;
            data_level_next    = 1'b0;
            if (chip_counter == CHIP_W'(NUM_CHIPS - 1)) begin
              chip_counter_next = '0;
              phase_next        = PH_IDLE;
              done              = 1'b1;
            end else begin
              chip_counter_next = chip_counter + 1'b1;
              word_counter_next = '0;
              bit_counter_next  = 4'd15;
              phase_next        = PH_SEND;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      chip_counter  <= '0;
      word_counter  <= '0;
      bit_counter   <= 4'd15;
      delay_counter <= '0;
      pulse_counter <= '0;
      clock_level   <= 1'b0;
      data_level    <= 1'b0;
      blank_mode    <= 1'b0;
    end else begin
      phase         <= phase_next;
      chip_counter  <= chip_counter_next;
      word_counter  <= word_counter_next;
      bit_counter   <= bit_counter_next;
      delay_counter <= delay_counter_next;
      pulse_counter <= pulse_counter_next;
      clock_level   <= clock_level_next;
      data_level    <= data_level_next;
      blank_mode    <= blank_mode_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.data_pin  <= data_level_next;
      out_ch.clock_pin <= clock_level_next;
      out_ch.busy_res  <= (phase_next != PH_IDLE);
      out_ch.all_done  <= done;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

@@ src/ldcs_checker.sv @@
module ldcs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic data_pin,
  input logic clock_pin,
  input logic busy_res,
  input logic all_done
);

  // the last latch returns the chain to idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_done |-> !busy_res)
    else $error("all_done shown while busy");

  // an empty output register never holds off input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item present after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_pin)
      && $stable(clock_pin) && $stable(busy_res) && $stable(all_done))
    else $error("stalled result item changed");

  // a taken item while output stalls is impossible
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_valid |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind led_driver_chain_serializer ldcs_checker u_ldcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_pin  (out_ch.data_pin),
  .clock_pin (out_ch.clock_pin),
  .busy_res  (out_ch.busy_res),
  .all_done  (out_ch.all_done)
);
